// File: src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_INS_WR,
    ST_SHIFT_DN,
    ST_FIND
  } state_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
    logic [4:0]         position;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] found_position;
    logic [4:0] count;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

// File: src/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer for insert, remove and find; walks the entry RAM one slot a cycle
// and holds the result register.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             out_res_o,
  output mem_req_t         mem_o,
  input  logic [DataW-1:0] rdata_i
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [DataW-1:0] val_q, val_d;
  res_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;

  logic [CntW-1:0]  cnt_m1;
  logic [AddrW-1:0] last_idx;
  logic [CntW-1:0]  pos_p1;

  assign cnt_m1   = cnt_q - CntW'(1);
  assign last_idx = cnt_m1[AddrW-1:0];
  assign pos_p1   = in_req_i.position + CntW'(1);

  assign in_stall_o  = (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !out_valid_q) begin
          val_d       = in_req_i.value;
          pos_d       = in_req_i.position[AddrW-1:0];
          out_valid_d = 1'b1;
          res_d       = '{status: STAT_OK, found_position: '0, count: cnt_q};
          case (in_req_i.op)
            OP_INSERT: begin
              if (in_req_i.position > cnt_q) begin
                res_d.status = STAT_BAD_POS;
              end else if (cnt_q == CntW'(DEPTH)) begin
                res_d.status = STAT_FULL;
              end else if (in_req_i.position == cnt_q) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = in_req_i.position[AddrW-1:0];
                mem_o.wdata = in_req_i.value;
                cnt_d       = cnt_q + CntW'(1);
                res_d.count = cnt_d;
              end else begin
                out_valid_d = 1'b0;
                mem_o.re    = 1'b1;
                mem_o.raddr = last_idx;
                addr_d      = last_idx;
                state_d     = ST_SHIFT_UP;
              end
            end
            OP_REMOVE: begin
              if (in_req_i.position >= cnt_q) begin
                res_d.status = STAT_BAD_POS;
              end else if (pos_p1 == cnt_q) begin
                cnt_d       = cnt_m1;
                res_d.count = cnt_m1;
              end else begin
                out_valid_d = 1'b0;
                mem_o.re    = 1'b1;
                mem_o.raddr = pos_p1[AddrW-1:0];
                addr_d      = pos_p1[AddrW-1:0];
                state_d     = ST_SHIFT_DN;
              end
            end
            OP_FIND: begin
              if (cnt_q == '0) begin
                res_d.status = STAT_NOT_FOUND;
              end else begin
                out_valid_d = 1'b0;
                mem_o.re    = 1'b1;
                mem_o.raddr = '0;
                addr_d      = '0;
                state_d     = ST_FIND;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT_UP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = addr_q + AddrW'(1);
        mem_o.wdata = rdata_i;
        if (addr_q == pos_q) begin
          state_d = ST_INS_WR;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = addr_q - AddrW'(1);
          addr_d      = addr_q - AddrW'(1);
        end
      end
      ST_INS_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = val_q;
        cnt_d       = cnt_q + CntW'(1);
        res_d       = '{status: STAT_OK, found_position: '0, count: cnt_d};
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SHIFT_DN: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = addr_q - AddrW'(1);
        mem_o.wdata = rdata_i;
        if (addr_q == last_idx) begin
          cnt_d       = cnt_m1;
          res_d       = '{status: STAT_OK, found_position: '0, count: cnt_m1};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = addr_q + AddrW'(1);
          addr_d      = addr_q + AddrW'(1);
        end
      end
      ST_FIND: begin
        if (rdata_i == val_q) begin
          res_d       = '{status: STAT_OK, found_position: addr_q, count: cnt_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (addr_q == last_idx) begin
          res_d       = '{status: STAT_NOT_FOUND, found_position: '0, count: cnt_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = addr_q + AddrW'(1);
          addr_d      = addr_q + AddrW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: src/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of signed 32-bit values with insert, remove and find.
// ----------------------------------------------------------------------------
// Entries live in a 16-entry RAM with one write and one registered read port;
// the sequencer moves one entry per cycle. Insert at p into n entries moves
// entries n-1..p up a slot, then writes the value at p (at once if p == n);
// remove at p moves entries above p down a slot (if p is the last, only the
// count drops); find compares from entry 0 to a match or the last. Rejected
// requests and unused op codes are answered from idle. The result is held in
// an output register; a new request is taken once that register is empty. No
// clearing is needed after reset: only entries below the count are ever read.
module positional_list_engine_unit import ple_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_res_o
);

  mem_req_t         mem_req;
  logic [DataW-1:0] rdata;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .mem_o      (mem_req),
    .rdata_i    (rdata)
  );

  ple_ram #(
    .Depth(DEPTH),
    .Width(DataW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(rdata)
  );

endmodule

// File: tb/sv/ple_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ple_list_checker
// Watches both channels of the positional list engine, keeps its own copy of
// the list, works out the result of every accepted request and compares each
// accepted result against the oldest one still owed. Reports the number of
// mismatches and the number of results still owed.
// ----------------------------------------------------------------------------
module ple_list_checker import ple_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  res_t        out_res_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  logic signed [DataW-1:0] list_q [DEPTH];
  logic [CntW-1:0]         len_q;
  res_t                    owed_q [$];
  int unsigned             mismatches;

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
    mismatches++;
  endtask

  task automatic apply_req(input req_t r, output res_t res);
    logic [CntW-1:0] i;
    logic [CntW-1:0] p;
    bit              hit;
    res.status         = STAT_OK;
    res.found_position = '0;
    p   = r.position;
    hit = 1'b0;
    case (r.op)
      OP_INSERT: begin
        if (p > len_q) begin
          res.status = STAT_BAD_POS;
        end else if (len_q >= CntW'(DEPTH)) begin
          res.status = STAT_FULL;
        end else begin
          for (i = len_q; i > p; i--) begin
            list_q[i[AddrW-1:0]] = list_q[i[AddrW-1:0] - AddrW'(1)];
          end
          list_q[p[AddrW-1:0]] = r.value;
          len_q++;
        end
      end
      OP_REMOVE: begin
        if (p >= len_q) begin
          res.status = STAT_BAD_POS;
        end else begin
          for (i = p; i + CntW'(1) < len_q; i++) begin
            list_q[i[AddrW-1:0]] = list_q[i[AddrW-1:0] + AddrW'(1)];
          end
          len_q--;
        end
      end
      OP_FIND: begin
        res.status = STAT_NOT_FOUND;
        for (i = '0; i < len_q && !hit; i++) begin
          if (list_q[i[AddrW-1:0]] == r.value) begin
            hit                = 1'b1;
            res.status         = STAT_OK;
            res.found_position = i[AddrW-1:0];
          end
        end
      end
      default: ;
    endcase
    res.count = len_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      len_q      = '0;
      mismatches = 0;
      owed_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        apply_req(in_req_i, want);
        owed_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with none owed: status %0d pos %0d count %0d", $time,
                     out_res_i.status, out_res_i.found_position, out_res_i.count);
          end
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (out_res_i.status !== want.status)
            note_mismatch("status", want.status, out_res_i.status);
          if (out_res_i.found_position !== want.found_position)
            note_mismatch("found_position", want.found_position, out_res_i.found_position);
          if (out_res_i.count !== want.count)
            note_mismatch("count", want.count, out_res_i.count);
        end
      end
      errors_o  <= mismatches;
      pending_o <= owed_q.size();
    end
  end

endmodule

// File: tb/sv/tb_positional_list_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Drives insert, remove and find requests into the positional list engine:
// a directed pass over the edge cases, then random phases that swing between
// filling and draining the list, with random gaps and stalls on both sides,
// one long result hold-off and pauses until all results are back. Checking
// is done by ple_list_checker.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit;
  import ple_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PHASES = 14;
  localparam int unsigned PHASE_LEN = 125;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  res_t        out_res;
  int unsigned fail_cnt;
  int unsigned pending;

  int unsigned fill_est = 0;
  bit          tx_quiet = 1'b0;

  positional_list_engine_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res)
  );

  ple_list_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_req_i   (in_req),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_res_i  (out_res),
    .errors_o   (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic req_t make_req(input logic [1:0] op, input logic [31:0] value,
                                    input int unsigned pos);
    req_t r;
    r.op       = op_e'(op);
    r.value    = value;
    r.position = pos[4:0];
    return r;
  endfunction

  function automatic logic [31:0] pool_value(input int unsigned idx);
    case (idx)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'h5555_5555;
      6:       return 32'hAAAA_AAAA;
      default: return 32'h0000_0007;
    endcase
  endfunction

  function automatic req_t rand_req(input int unsigned insert_pct);
    int unsigned k;
    logic [1:0]  op;
    logic [31:0] value;
    int unsigned pos;
    k = $urandom_range(0, 99);
    if (k < 3)       op = OP_UNUSED;
    else if (k < 33) op = OP_FIND;
    else             op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    value = ($urandom_range(0, 9) < 6) ? pool_value($urandom_range(0, 7)) : $urandom;
    k = $urandom_range(0, 99);
    if (k < 85)      pos = $urandom_range(0, fill_est);
    else if (k < 95) pos = $urandom_range(0, DEPTH);
    else             pos = $urandom_range(0, 31);
    return make_req(op, value, pos);
  endfunction

  task automatic send_req(input req_t r);
    int unsigned gap;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.op == OP_INSERT && r.position <= fill_est && fill_est < DEPTH) fill_est++;
    else if (r.op == OP_REMOVE && r.position < fill_est) fill_est--;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : result_sink
    int unsigned taken;
    int unsigned hold_n;
    bit          rx_quiet;
    taken    = 0;
    rx_quiet = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        taken++;
        if (taken % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        if (taken == 500)  hold_n = 400;
        else if (rx_quiet) hold_n = 0;
        else               hold_n = $urandom_range(0, 16);
        if (hold_n > 0) begin
          out_stall <= 1'b1;
          repeat (hold_n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : request_source
    int unsigned insert_pct;
    int unsigned ph;
    int unsigned n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: find, remove and insert past the end
    send_req(make_req(OP_FIND, 32'h0000_0005, 0));
    send_req(make_req(OP_REMOVE, 32'h0, 0));
    send_req(make_req(OP_INSERT, 32'h1234_5678, 1));
    // build [-1, 0, min, max]
    send_req(make_req(OP_INSERT, 32'h8000_0000, 0));
    send_req(make_req(OP_INSERT, 32'h7FFF_FFFF, 1));
    send_req(make_req(OP_INSERT, 32'hFFFF_FFFF, 0));
    send_req(make_req(OP_INSERT, 32'h0000_0000, 1));
    send_req(make_req(OP_FIND, 32'h7FFF_FFFF, 31));
    send_req(make_req(OP_FIND, 32'hFFFF_FFFF, 0));
    send_req(make_req(OP_FIND, 32'h8000_0000, 7));
    send_req(make_req(OP_FIND, 32'h7FFF_FFFE, 0));
    send_req(make_req(OP_UNUSED, 32'hFFFF_FFFF, 31));
    send_req(make_req(OP_REMOVE, 32'hFFFF_FFFF, 31));
    send_req(make_req(OP_INSERT, 32'h0000_0001, 31));
    send_req(make_req(OP_REMOVE, 32'h0, 4));
    send_req(make_req(OP_REMOVE, 32'h0, 3));
    send_req(make_req(OP_REMOVE, 32'h0, 0));
    send_req(make_req(OP_FIND, 32'h8000_0000, 0));

    for (ph = 0; ph < PHASES; ph++) begin
      insert_pct = $urandom_range(20, 85);
      tx_quiet   = ($urandom_range(0, 3) == 0);
      if (ph == 4 || ph == 9) drain_results();
      for (n = 0; n < PHASE_LEN; n++) send_req(rand_req(insert_pct));
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: positional_list_engine_unit.f
src/ple_pkg.sv
src/ple_ram.sv
src/ple_ctrl.sv
src/positional_list_engine_unit.sv
tb/sv/ple_list_checker.sv
tb/sv/tb_positional_list_engine_unit.sv
